/* src/wai_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wai_pkg: shared types and constants for the windowed Amihud ratio unit
// Field widths, status codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package wai_pkg;

  localparam int PRICE_W    = 32;
  localparam int VOL_W      = 24;
  localparam int PROD_W     = PRICE_W + VOL_W;
  localparam int SUM_W      = 64;
  localparam int HALF_W     = SUM_W / 2;
  localparam int RESULT_W   = 64;
  localparam int FRAC_SHIFT = 56;
  localparam int TPW_W      = 10;

  localparam logic [TPW_W-1:0] TPW_RESET = 10'd390;

  typedef enum logic [1:0] {
    WS_OK        = 2'd0,
    WS_SINGLE    = 2'd1,
    WS_ZERO_DIV  = 2'd2,
    WS_SATURATED = 2'd3
  } win_status_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic form_den;
    logic div_step;
    logic finish;
  } ratio_cmd_t;

  typedef struct packed {
    logic no_divide;
  } ratio_flags_t;

endpackage

/* src/windowed_amihud_illiquidity_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_amihud_illiquidity_unit: windowed Amihud ratio over a trade stream
// Trades enter on the trade channel (trade_valid / trade_stall) and one result
// leaves on the result channel (result_valid / result_stall) per closed window.
// A window closes after trades_per_window trades or on a trade marked
// end_of_stream. cfg_write loads trades_per_window (0 acts as 1, values above
// MAX_WINDOW clamp); write it only while the unit is idle.
// Trades are accepted one per cycle while no closing trade is stalled. A closed
// window is ratioed while the next window accumulates: two multiply steps, a
// divisor add and one restoring divider step per quotient bit (88 plus the
// bit width of VOLUME_SCALE steps, 108 at the default). The result is
// registered in S_FIN and offered in S_HOLD; single-trade and zero-divisor
// windows skip the second multiply, the divisor add and the divider. A request
// that would close the next window is stalled until the previous result is taken.
// While result_stall is high the result holds in its register and non-closing
// trades keep flowing. Synchronous reset clears the window, drops any pending
// result and sets trades_per_window to 390.
// ----------------------------------------------------------------------------
module windowed_amihud_illiquidity_unit import wai_pkg::*; #(
  parameter int MAX_WINDOW   = 1023,
  parameter int VOLUME_SCALE = 1000000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                trade_valid,
  output logic                trade_stall,
  input  logic [PRICE_W-1:0]  trade_price,
  input  logic [VOL_W-1:0]    trade_volume,
  input  logic                end_of_stream,
  input  logic                cfg_write,
  input  logic [TPW_W-1:0]    cfg_data,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [RESULT_W-1:0] illiquidity,
  output logic [TPW_W-1:0]    window_trades,
  output logic [1:0]          window_status
);

  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SCALE_W = $clog2(VOLUME_SCALE + 1);
  localparam int NUM_W   = PRICE_W + SCALE_W + FRAC_SHIFT;
  localparam int WIDE_W  = (CNT_W > TPW_W) ? CNT_W : TPW_W;

  logic [TPW_W-1:0]   tpw;
  logic [WIDE_W-1:0]  tpw_wide;
  logic [CNT_W-1:0]   limit;

  logic               window_done;
  logic [PRICE_W-1:0] snap_open;
  logic [PRICE_W-1:0] snap_last;
  logic [CNT_W-1:0]   snap_count;
  logic [SUM_W-1:0]   sum;
  logic               sum_ovf;
  logic               ctrl_busy;
  ratio_cmd_t         cmd;
  ratio_flags_t       flags;
  win_status_t        status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpw <= TPW_RESET;
    end else if (cfg_write) begin
      tpw <= cfg_data;
    end
  end

  assign tpw_wide = WIDE_W'(tpw);

  always_comb begin
    if (tpw == '0) begin
      limit = CNT_W'(1);
    end else if (tpw_wide > WIDE_W'(MAX_WINDOW)) begin
      limit = CNT_W'(MAX_WINDOW);
    end else begin
      limit = tpw_wide[CNT_W-1:0];
    end
  end

  wai_accum #(
    .CNT_W(CNT_W)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .valid      (trade_valid),
    .stall      (trade_stall),
    .price      (trade_price),
    .volume     (trade_volume),
    .eos        (end_of_stream),
    .limit      (limit),
    .job_busy   (ctrl_busy),
    .window_done(window_done),
    .snap_open  (snap_open),
    .snap_last  (snap_last),
    .snap_count (snap_count),
    .sum        (sum),
    .sum_ovf    (sum_ovf)
  );

  wai_ratio_dp #(
    .CNT_W       (CNT_W),
    .VOLUME_SCALE(VOLUME_SCALE)
  ) u_ratio (
    .clk          (clk),
    .cmd          (cmd),
    .snap_open    (snap_open),
    .snap_last    (snap_last),
    .snap_count   (snap_count),
    .sum          (sum),
    .sum_ovf      (sum_ovf),
    .flags        (flags),
    .illiquidity  (illiquidity),
    .window_trades(window_trades),
    .window_status(status_q)
  );

  wai_ctrl #(
    .DIV_STEPS(NUM_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .window_done (window_done),
    .flags       (flags),
    .result_stall(result_stall),
    .cmd         (cmd),
    .busy        (ctrl_busy),
    .result_valid(result_valid)
  );

  assign window_status = status_q;

`ifndef SYNTHESIS
  // A finished window must find the ratio controller idle.
  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    window_done |-> !ctrl_busy)
    else $error("window closed while the ratio path was busy");

  a_single_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status_q == WS_SINGLE)) |-> (illiquidity == '0))
    else $error("single-trade window reported a nonzero ratio");

  a_zero_div_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status_q == WS_ZERO_DIV)) |-> (illiquidity == '0))
    else $error("zero-divisor window reported a nonzero ratio");

  a_load_then_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.mul_lo)
    else $error("ratio load not followed by the first multiply");
`endif

endmodule

/* src/wai_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wai_accum: trade window accumulator
// Counts trades, keeps opening and closing prices and a saturating sum of
// price times volume, and snapshots a window when it closes.
// ----------------------------------------------------------------------------
module wai_accum import wai_pkg::*; #(
  parameter int CNT_W = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  logic [PRICE_W-1:0]  price,
  input  logic [VOL_W-1:0]    volume,
  input  logic                eos,
  input  logic [CNT_W-1:0]    limit,
  input  logic                job_busy,
  output logic                window_done,
  output logic [PRICE_W-1:0]  snap_open,
  output logic [PRICE_W-1:0]  snap_last,
  output logic [CNT_W-1:0]    snap_count,
  output logic [SUM_W-1:0]    sum,
  output logic                sum_ovf
);

  logic [CNT_W-1:0]   count;
  logic [CNT_W:0]     count_inc;
  logic [PRICE_W-1:0] opening;
  logic               close_in;
  logic               accept;
  logic [PROD_W-1:0]  prod;

  logic [PROD_W-1:0]  b_prod;
  logic               b_valid;
  logic               b_start;
  logic               b_close;

  logic [SUM_W-1:0]   base;
  logic [SUM_W:0]     sum_add;

  assign count_inc = (CNT_W+1)'(count) + (CNT_W+1)'(1);
  assign close_in  = (count_inc >= (CNT_W+1)'(limit)) || eos;

  // A closing request waits until the previous window has left the ratio path.
  assign stall  = close_in && (job_busy || (b_valid && b_close) || window_done);
  assign accept = valid && !stall;
  assign prod   = PROD_W'(price) * PROD_W'(volume);

  assign base    = b_start ? '0 : sum;
  assign sum_add = (SUM_W+1)'(base) + (SUM_W+1)'(b_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      b_valid     <= 1'b0;
      b_close     <= 1'b0;
      window_done <= 1'b0;
    end else begin
      b_valid     <= accept;
      window_done <= b_valid && b_close;
      if (accept) begin
        b_close <= close_in;
        if (close_in) begin
          count <= '0;
        end else begin
          count <= count_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_prod  <= prod;
      b_start <= (count == '0);
      if (count == '0) begin
        opening <= price;
      end
      if (close_in) begin
        snap_open  <= (count == '0) ? price : opening;
        snap_last  <= price;
        snap_count <= count_inc[CNT_W-1:0];
      end
    end
    if (b_valid) begin
      if (sum_add[SUM_W] || (!b_start && sum_ovf)) begin
        sum     <= '1;
        sum_ovf <= 1'b1;
      end else begin
        sum     <= sum_add[SUM_W-1:0];
        sum_ovf <= 1'b0;
      end
    end
  end

endmodule

/* src/wai_ratio_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wai_ratio_dp: ratio datapath
// Forms numerator and divisor with split multiplies, then runs a restoring
// divider one quotient bit per step and packs the result and status.
// ----------------------------------------------------------------------------
module wai_ratio_dp import wai_pkg::*; #(
  parameter int CNT_W        = 10,
  parameter int VOLUME_SCALE = 1000000
) (
  input  logic                clk,
  input  ratio_cmd_t          cmd,
  input  logic [PRICE_W-1:0]  snap_open,
  input  logic [PRICE_W-1:0]  snap_last,
  input  logic [CNT_W-1:0]    snap_count,
  input  logic [SUM_W-1:0]    sum,
  input  logic                sum_ovf,
  output ratio_flags_t        flags,
  output logic [RESULT_W-1:0] illiquidity,
  output logic [TPW_W-1:0]    window_trades,
  output win_status_t         window_status
);

  localparam int SCALE_W  = $clog2(VOLUME_SCALE + 1);
  localparam int SCALED_W = PRICE_W + SCALE_W;
  localparam int NUM_W    = SCALED_W + FRAC_SHIFT;
  localparam int DEN_W    = PRICE_W + SUM_W;
  localparam int PP_W     = PRICE_W + HALF_W;
  localparam int WIDE_W   = (CNT_W > TPW_W) ? CNT_W : TPW_W;

  logic [PRICE_W-1:0]  op;
  logic [PRICE_W-1:0]  diff;
  logic [CNT_W-1:0]    cnt;
  logic [SUM_W-1:0]    sum_r;
  logic                ovf;
  logic                single;
  logic                zero;
  logic [SCALED_W-1:0] scaled;
  logic [PP_W-1:0]     plo;
  logic [PP_W-1:0]     phi;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    rem;
  logic [NUM_W-1:0]    num;

  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_sub;
  logic                ge;
  logic                sat;
  logic [WIDE_W-1:0]   cnt_wide;

  assign rem_sh   = {rem, num[NUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, den};
  assign ge       = (rem_sh >= {1'b0, den});
  assign sat      = |num[NUM_W-1:RESULT_W];
  assign cnt_wide = WIDE_W'(cnt);

  assign flags.no_divide = single || zero;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= snap_open;
      diff   <= (snap_last >= snap_open) ? (snap_last - snap_open) : (snap_open - snap_last);
      cnt    <= snap_count;
      sum_r  <= sum;
      ovf    <= sum_ovf;
      single <= (snap_count == CNT_W'(1));
      zero   <= (snap_open == '0) || (sum == '0);
    end
    if (cmd.mul_lo) begin
      scaled <= SCALED_W'(diff) * SCALED_W'(VOLUME_SCALE);
      plo    <= PP_W'(op) * PP_W'(sum_r[HALF_W-1:0]);
    end
    if (cmd.mul_hi) begin
      phi <= PP_W'(op) * PP_W'(sum_r[SUM_W-1:HALF_W]);
    end
    if (cmd.form_den) begin
      den <= {phi, {HALF_W{1'b0}}} + DEN_W'(plo);
      num <= {scaled, {FRAC_SHIFT{1'b0}}};
      rem <= '0;
    end
    // The numerator register shifts out dividend bits and collects quotient bits.
    if (cmd.div_step) begin
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num <= {num[NUM_W-2:0], ge};
    end
    if (cmd.finish) begin
      window_trades <= cnt_wide[TPW_W-1:0];
      if (single) begin
        illiquidity   <= '0;
        window_status <= WS_SINGLE;
      end else if (zero) begin
        illiquidity   <= '0;
        window_status <= WS_ZERO_DIV;
      end else if (sat) begin
        illiquidity   <= '1;
        window_status <= WS_SATURATED;
      end else begin
        illiquidity   <= num[RESULT_W-1:0];
        window_status <= ovf ? WS_SATURATED : WS_OK;
      end
    end
  end

endmodule

/* src/wai_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wai_ctrl: ratio controller
// Sequences load, multiply, divide and result hand-off for each closed window.
// ----------------------------------------------------------------------------
module wai_ctrl import wai_pkg::*; #(
  parameter int DIV_STEPS = 108
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         window_done,
  input  ratio_flags_t flags,
  input  logic         result_stall,
  output ratio_cmd_t   cmd,
  output logic         busy,
  output logic         result_valid
);

  localparam int ITER_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_DEN,
    S_DIV,
    S_FIN,
    S_HOLD
  } state_t;

  state_t            state;
  logic [ITER_W-1:0] iter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (window_done) state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          // Single-trade and zero-divisor windows skip the divider.
          state <= flags.no_divide ? S_FIN : S_MUL_HI;
        end
        S_MUL_HI: begin
          state <= S_DEN;
        end
        S_DEN: begin
          state <= S_DIV;
          iter  <= ITER_W'(DIV_STEPS - 1);
        end
        S_DIV: begin
          if (iter == '0) begin
            state <= S_FIN;
          end else begin
            iter <= iter - ITER_W'(1);
          end
        end
        S_FIN: begin
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (!result_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && window_done;
    cmd.mul_lo   = (state == S_MUL_LO);
    cmd.mul_hi   = (state == S_MUL_HI);
    cmd.form_den = (state == S_DEN);
    cmd.div_step = (state == S_DIV);
    cmd.finish   = (state == S_FIN);
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_HOLD);

endmodule
